@@ design/abd_pkg.sv @@
// ----------------------------------------------------------------------------
// abd_pkg: shared types and codes of the aligned block binary differ
// record kinds, register indexes and the structs passed between the stages
// ----------------------------------------------------------------------------
package abd_pkg;

    // record kinds as seen on the result port
    typedef enum logic [1:0] {
        KIND_RUN     = 2'd0,
        KIND_ADDED   = 2'd1,
        KIND_REMOVED = 2'd2,
        KIND_SUMMARY = 2'd3
    } t_kind;

    // configuration register indexes
    localparam logic [2:0] CFG_ALIGN = 3'd0;
    localparam logic [2:0] CFG_BASE  = 3'd1;
    localparam logic [2:0] CFG_IGN0  = 3'd2;
    localparam logic [2:0] CFG_IGN1  = 3'd3;
    localparam logic [2:0] CFG_IGN2  = 3'd4;
    localparam logic [2:0] CFG_IGN3  = 3'd5;

    // register file contents
    typedef struct packed {
        logic [1:0]       align_log2;
        logic [31:0]      base_address;
        logic [3:0][63:0] ignore_map;
    } t_cfg;

    // one byte position of both images
    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic       has_a;
        logic       has_b;
        logic       last_item;
    } t_item;

    // every record that one request can cause, in port widths
    typedef struct packed {
        logic        run_v;
        logic [31:0] run_address;
        logic [31:0] run_length;
        logic        run_both;
        logic        tail_v;
        t_kind       tail_kind;
        logic [31:0] tail_address;
        logic [31:0] tail_length;
        logic        sum_v;
        logic [31:0] matched_bytes;
        logic [31:0] compared_bytes;
        logic [31:0] total_blocks;
        logic [31:0] changed_runs;
        logic [31:0] unchanged_blocks;
    } t_pkt;

endpackage

@@ design/abd_cfg.sv @@
// ----------------------------------------------------------------------------
// abd_cfg: configuration registers
// block size, base address and the 256-bit ignore set, written one at a time
// ----------------------------------------------------------------------------
module abd_cfg
    import abd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // writes are always taken, unknown indexes are dropped
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                CFG_ALIGN: r_cfg.align_log2   <= i_cfg_data[1:0];
                CFG_BASE:  r_cfg.base_address <= i_cfg_data[31:0];
                CFG_IGN0, CFG_IGN1, CFG_IGN2, CFG_IGN3: begin
                    r_cfg.ignore_map[2'(i_cfg_index - CFG_IGN0)] <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

endmodule

@@ design/abd_core.sv @@
// ----------------------------------------------------------------------------
// abd_core: input register and comparison state
// compares a byte pair per cycle unless stalled; closes blocks, builds records
// ----------------------------------------------------------------------------
module abd_core
    import abd_pkg::*;
#(
    parameter int ADDR_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_in_valid,
    input  t_item i_item,
    output logic  o_in_stall,
    input  logic  i_pkt_ready,
    output logic  o_pkt_load,
    output t_pkt  o_pkt
);

    typedef logic [ADDR_BITS-1:0] t_addr;

    // offset to 32-bit port value
    function automatic logic [31:0] to32(input t_addr v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    // base plus offset, wrapping at the address width
    function automatic logic [31:0] addr_out(input logic [31:0] base, input t_addr off);
        logic [63:0] b;
        b = 64'(base);
        return to32(t_addr'(b[ADDR_BITS-1:0] + off));
    endfunction

    logic  r_in_valid;
    t_item r_item;
    logic  advance;

    t_addr       r_position, r_run_start, r_length_a, r_length_b, r_block_start;
    logic [3:0]  r_block_fill;
    logic        r_block_differs, r_in_run, r_run_both, r_block_first_both;
    logic [31:0] r_matched, r_compared, r_changed, r_block_count;

    t_addr       n_position, n_run_start, n_length_a, n_length_b, n_block_start;
    logic [3:0]  n_block_fill;
    logic        n_block_differs, n_in_run, n_run_both, n_block_first_both;
    logic [31:0] n_matched, n_compared, n_changed, n_block_count;
    t_pkt        pkt;

    // input register: refills in the same cycle it hands over
    assign advance    = r_in_valid && i_pkt_ready;
    assign o_in_stall = r_in_valid && !i_pkt_ready;
    assign o_pkt_load = advance;
    assign o_pkt      = pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_item;
        end
    end

    // per-position compare, block close and record build
    always_comb begin
        logic       ign_a, ign_b, byte_diff, close, first_both;
        logic [7:0] va, vb;
        logic [3:0] filled, size;
        t_addr      next, bstart;
        logic [32:0] used, total;

        n_position         = r_position;
        n_run_start        = r_run_start;
        n_length_a         = r_length_a;
        n_length_b         = r_length_b;
        n_block_start      = r_block_start;
        n_block_fill       = r_block_fill;
        n_block_differs    = r_block_differs;
        n_in_run           = r_in_run;
        n_run_both         = r_run_both;
        n_block_first_both = r_block_first_both;
        n_matched          = r_matched;
        n_compared         = r_compared;
        n_changed          = r_changed;
        n_block_count      = r_block_count;
        pkt                = '0;
        used               = '0;
        total              = '0;

        // block start is latched on its first byte
        first_both = r_item.has_a && r_item.has_b;
        bstart     = (r_block_fill == 4'd0) ? r_position : r_block_start;
        if (r_block_fill == 4'd0) begin
            n_block_first_both = first_both;
        end
        n_block_start = bstart;

        // ignore set lookup and byte compare
        ign_a     = !r_item.has_a || i_cfg.ignore_map[r_item.byte_a[7:6]][r_item.byte_a[5:0]];
        ign_b     = !r_item.has_b || i_cfg.ignore_map[r_item.byte_b[7:6]][r_item.byte_b[5:0]];
        va        = r_item.has_a ? r_item.byte_a : 8'd0;
        vb        = r_item.has_b ? r_item.byte_b : 8'd0;
        byte_diff = !(ign_a && ign_b) && (va != vb);
        n_block_differs = r_block_differs || byte_diff;

        // image lengths and position
        next = r_position + t_addr'(1);
        if (r_item.has_a) begin
            n_length_a = next;
        end
        if (r_item.has_b) begin
            n_length_b = next;
        end
        n_position = next;

        filled       = r_block_fill + 4'd1;
        size         = 4'd1 << i_cfg.align_log2;
        close        = (filled >= size) || r_item.last_item;
        n_block_fill = filled;

        // block close: counters, run open or run end
        if (close) begin
            n_block_count = r_block_count + 32'd1;
            n_compared    = r_compared + 32'(filled);
            if (n_block_differs) begin
                if (!r_in_run) begin
                    n_in_run    = 1'b1;
                    n_run_start = bstart;
                    n_run_both  = n_block_first_both;
                    n_changed   = r_changed + 32'(n_block_first_both);
                end
            end else begin
                n_matched = r_matched + 32'(filled);
                if (r_in_run) begin
                    pkt.run_v       = 1'b1;
                    pkt.run_address = addr_out(i_cfg.base_address, r_run_start);
                    pkt.run_length  = to32(bstart - r_run_start);
                    pkt.run_both    = r_run_both;
                    n_in_run        = 1'b0;
                end
            end
            n_block_fill    = 4'd0;
            n_block_differs = 1'b0;
        end

        // end of comparison: open run, tail, summary
        if (r_item.last_item) begin
            if (n_in_run) begin
                pkt.run_v       = 1'b1;
                pkt.run_address = addr_out(i_cfg.base_address, n_run_start);
                pkt.run_length  = to32(next - n_run_start);
                pkt.run_both    = n_run_both;
            end
            if (n_length_b > n_length_a) begin
                pkt.tail_v       = 1'b1;
                pkt.tail_kind    = KIND_ADDED;
                pkt.tail_address = addr_out(i_cfg.base_address, n_length_a);
                pkt.tail_length  = to32(n_length_b - n_length_a);
            end else if (n_length_a > n_length_b) begin
                pkt.tail_v       = 1'b1;
                pkt.tail_kind    = KIND_REMOVED;
                pkt.tail_address = addr_out(i_cfg.base_address, n_length_b);
                pkt.tail_length  = to32(n_length_a - n_length_b);
            end
            used                 = {1'b0, n_changed} + 33'(pkt.tail_v);
            total                = {1'b0, n_block_count};
            pkt.sum_v            = 1'b1;
            pkt.matched_bytes    = n_matched;
            pkt.compared_bytes   = n_compared;
            pkt.total_blocks     = n_block_count;
            pkt.changed_runs     = n_changed;
            pkt.unchanged_blocks = (total > used) ? 32'(total - used) : 32'd0;

            n_position         = '0;
            n_run_start        = '0;
            n_length_a         = '0;
            n_length_b         = '0;
            n_block_start      = '0;
            n_block_fill       = 4'd0;
            n_block_differs    = 1'b0;
            n_in_run           = 1'b0;
            n_run_both         = 1'b0;
            n_block_first_both = 1'b0;
            n_matched          = 32'd0;
            n_compared         = 32'd0;
            n_changed          = 32'd0;
            n_block_count      = 32'd0;
        end
    end

    // comparison state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position         <= '0;
            r_run_start        <= '0;
            r_length_a         <= '0;
            r_length_b         <= '0;
            r_block_start      <= '0;
            r_block_fill       <= 4'd0;
            r_block_differs    <= 1'b0;
            r_in_run           <= 1'b0;
            r_run_both         <= 1'b0;
            r_block_first_both <= 1'b0;
            r_matched          <= 32'd0;
            r_compared         <= 32'd0;
            r_changed          <= 32'd0;
            r_block_count      <= 32'd0;
        end else if (advance) begin
            r_position         <= n_position;
            r_run_start        <= n_run_start;
            r_length_a         <= n_length_a;
            r_length_b         <= n_length_b;
            r_block_start      <= n_block_start;
            r_block_fill       <= n_block_fill;
            r_block_differs    <= n_block_differs;
            r_in_run           <= n_in_run;
            r_run_both         <= n_run_both;
            r_block_first_both <= n_block_first_both;
            r_matched          <= n_matched;
            r_compared         <= n_compared;
            r_changed          <= n_changed;
            r_block_count      <= n_block_count;
        end
    end

endmodule

@@ design/abd_out.sv @@
// ----------------------------------------------------------------------------
// abd_out: result register and record serialiser
// holds the records of one request and hands them out run, tail, summary
// ----------------------------------------------------------------------------
module abd_out
    import abd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pkt_load,
    input  t_pkt        i_pkt,
    output logic        o_pkt_ready,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_record_kind,
    output logic [31:0] o_address,
    output logic [31:0] o_length,
    output logic        o_both_present,
    output logic [31:0] o_matched_bytes,
    output logic [31:0] o_compared_bytes,
    output logic [31:0] o_total_blocks,
    output logic [31:0] o_changed_runs,
    output logic [31:0] o_unchanged_blocks,
    output logic        o_last_result
);

    // pending records: bit 0 run, bit 1 tail, bit 2 summary
    logic [2:0] r_pend;
    t_pkt       r_pkt;
    logic       take;
    t_kind      kind;

    assign o_out_valid = |r_pend;
    assign take        = o_out_valid && !i_out_stall;
    assign o_pkt_ready = (r_pend == 3'b000) || (take && $onehot(r_pend));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'b000;
        end else if (i_pkt_load) begin
            r_pend <= {i_pkt.sum_v, i_pkt.tail_v, i_pkt.run_v};
        end else if (take) begin
            r_pend <= r_pend & (r_pend - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt_load) begin
            r_pkt <= i_pkt;
        end
    end

    // head record select, unused fields read zero
    always_comb begin
        kind               = KIND_SUMMARY;
        o_address          = 32'd0;
        o_length           = 32'd0;
        o_both_present     = 1'b0;
        o_matched_bytes    = 32'd0;
        o_compared_bytes   = 32'd0;
        o_total_blocks     = 32'd0;
        o_changed_runs     = 32'd0;
        o_unchanged_blocks = 32'd0;
        o_last_result      = 1'b0;
        if (r_pend[0]) begin
            kind           = KIND_RUN;
            o_address      = r_pkt.run_address;
            o_length       = r_pkt.run_length;
            o_both_present = r_pkt.run_both;
        end else if (r_pend[1]) begin
            kind      = r_pkt.tail_kind;
            o_address = r_pkt.tail_address;
            o_length  = r_pkt.tail_length;
        end else begin
            o_matched_bytes    = r_pkt.matched_bytes;
            o_compared_bytes   = r_pkt.compared_bytes;
            o_total_blocks     = r_pkt.total_blocks;
            o_changed_runs     = r_pkt.changed_runs;
            o_unchanged_blocks = r_pkt.unchanged_blocks;
            o_last_result      = 1'b1;
        end
    end

    assign o_record_kind = kind;

endmodule

@@ design/aligned_block_binary_differ.sv @@
// ----------------------------------------------------------------------------
// aligned_block_binary_differ: aligned block binary compare
// streams byte pairs of two images and reports differing runs, tail, summary
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    byte_a, byte_b, has_a, has_b, last_item
//  result    out        o_out_valid / i_out_stall  record fields, up to 3 per request
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  one byte pair per cycle while the input is not stalled; a request is taken into the
//  input register and its records are valid once the result register has loaded them
//  a request holding n records (n up to 3) keeps the result register until all are taken
//  the rate is set by the result register draining records one per cycle when not stalled
//  reset is synchronous, clears valid flags, config and comparison state, no clearing pass
//  a stalled result holds; the input stalls only while the result register is full
// ----------------------------------------------------------------------------
module aligned_block_binary_differ
    import abd_pkg::*;
#(
    parameter int ADDR_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // byte pairs
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_a,
    input  logic [7:0]  i_byte_b,
    input  logic        i_has_a,
    input  logic        i_has_b,
    input  logic        i_last_item,
    // records
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_record_kind,
    output logic [31:0] o_address,
    output logic [31:0] o_length,
    output logic        o_both_present,
    output logic [31:0] o_matched_bytes,
    output logic [31:0] o_compared_bytes,
    output logic [31:0] o_total_blocks,
    output logic [31:0] o_changed_runs,
    output logic [31:0] o_unchanged_blocks,
    output logic        o_last_result
);

    t_cfg  cfg;
    t_item item;
    t_pkt  pkt;
    logic  pkt_load, pkt_ready;

    assign item = '{byte_a:    i_byte_a,
                    byte_b:    i_byte_b,
                    has_a:     i_has_a,
                    has_b:     i_has_b,
                    last_item: i_last_item};

    // register file
    abd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // compare stage
    abd_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .i_item      (item),
        .o_in_stall  (o_in_stall),
        .i_pkt_ready (pkt_ready),
        .o_pkt_load  (pkt_load),
        .o_pkt       (pkt)
    );

    // result stage
    abd_out u_out (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_pkt_load         (pkt_load),
        .i_pkt              (pkt),
        .o_pkt_ready        (pkt_ready),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_record_kind      (o_record_kind),
        .o_address          (o_address),
        .o_length           (o_length),
        .o_both_present     (o_both_present),
        .o_matched_bytes    (o_matched_bytes),
        .o_compared_bytes   (o_compared_bytes),
        .o_total_blocks     (o_total_blocks),
        .o_changed_runs     (o_changed_runs),
        .o_unchanged_blocks (o_unchanged_blocks),
        .o_last_result      (o_last_result)
    );

endmodule

@@ design/abd_checker.sv @@
// ----------------------------------------------------------------------------
// abd_checker: port level checks of the differ
// record consistency, stall behaviour and reset, bound to the top level
// ----------------------------------------------------------------------------
module abd_checker
    import abd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_record_kind,
    input logic [31:0] o_address,
    input logic [31:0] o_length,
    input logic [31:0] o_matched_bytes,
    input logic [31:0] o_total_blocks,
    input logic        o_last_result
);

    // the end flag rides on the summary only
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_result |-> o_record_kind == KIND_SUMMARY)
    else $error("end flag on a record other than the summary");

    // run and tail records carry no counters
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind != KIND_SUMMARY
        |-> !o_last_result && o_matched_bytes == 32'd0 && o_total_blocks == 32'd0)
    else $error("counters on a run or tail record");

    // a stalled record holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall
        |=> o_out_valid && $stable(o_record_kind) && $stable(o_address)
            && $stable(o_length))
    else $error("stalled record changed");

    // input waits only behind a pending record
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
    else $error("input stalled with no record pending");

    // reset empties the result register
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
    else $error("records pending after reset");

endmodule

bind aligned_block_binary_differ abd_checker u_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the aligned block binary differ
// streams byte pairs of two images through the block under random idling on
// both channels and checks every record against a cycle-free predictor that
// tracks blocks, runs, image lengths and summary counters
// ----------------------------------------------------------------------------
module tb;
    import abd_pkg::*;

    localparam int RANDOM_ITEMS  = 270;
    localparam int PHASE_ITEMS   = 30;
    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 60;
    localparam int REPORT_MAX    = 10;

    // idling modes for either side
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_LIGHT = 1;
    localparam int IDLE_HEAVY = 2;

    // indexes past the register file, writes there are dropped
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // one record as seen on the result port
    typedef struct packed {
        t_kind       kind;
        logic [31:0] address;
        logic [31:0] length;
        logic        both;
        logic [31:0] matched;
        logic [31:0] compared;
        logic [31:0] total;
        logic [31:0] changed;
        logic [31:0] unchanged;
        logic        last;
    } t_record;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_byte_a = '0;
    logic [7:0]  i_byte_b = '0;
    logic        i_has_a = 1'b0;
    logic        i_has_b = 1'b0;
    logic        i_last_item = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_record_kind;
    logic [31:0] o_address;
    logic [31:0] o_length;
    logic        o_both_present;
    logic [31:0] o_matched_bytes;
    logic [31:0] o_compared_bytes;
    logic [31:0] o_total_blocks;
    logic [31:0] o_changed_runs;
    logic [31:0] o_unchanged_blocks;
    logic        o_last_result;

    aligned_block_binary_differ dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_byte_a           (i_byte_a),
        .i_byte_b           (i_byte_b),
        .i_has_a            (i_has_a),
        .i_has_b            (i_has_b),
        .i_last_item        (i_last_item),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_record_kind      (o_record_kind),
        .o_address          (o_address),
        .o_length           (o_length),
        .o_both_present     (o_both_present),
        .o_matched_bytes    (o_matched_bytes),
        .o_compared_bytes   (o_compared_bytes),
        .o_total_blocks     (o_total_blocks),
        .o_changed_runs     (o_changed_runs),
        .o_unchanged_blocks (o_unchanged_blocks),
        .o_last_result      (o_last_result)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shared bench state
    t_item   pending_items[$];
    t_record expected_records[$];
    int      in_idle_mode = IDLE_NONE;
    int      out_idle_mode = IDLE_NONE;
    int      hold_asked = 0;
    bit      in_taken = 1'b0;
    int      fails = 0;
    int      pairs_taken = 0;
    int      compares_done = 0;
    int      runs_seen = 0;
    int      tails_seen = 0;
    int      summaries_seen = 0;
    int      n_settings = 0;

    // register copies
    logic [1:0]       cur_align = '0;
    logic [31:0]      cur_base = '0;
    logic [3:0][63:0] cur_ignore = '0;

    // comparison state
    logic [31:0] cmp_pos, blk_start, run_start, len_a, len_b;
    logic [31:0] matched, compared, changed, blk_total;
    logic [3:0]  blk_fill;
    logic        blk_diff, blk_first_both, in_run, run_both;

    task automatic clear_compare_state();
        cmp_pos = '0; blk_start = '0; run_start = '0; len_a = '0; len_b = '0;
        matched = '0; compared = '0; changed = '0; blk_total = '0;
        blk_fill = '0; blk_diff = 1'b0; blk_first_both = 1'b0;
        in_run = 1'b0; run_both = 1'b0;
    endtask

    initial clear_compare_state();

    function automatic bit in_ignore_set(input logic [7:0] v);
        return cur_ignore[v[7:6]][v[5:0]];
    endfunction

    // run or tail record, counters zero
    task automatic expect_span(input t_kind kind, input logic [31:0] offset,
                               input logic [31:0] len, input logic both);
        t_record r;
        r = '0;
        r.kind = kind;
        r.address = cur_base + offset;
        r.length = len;
        r.both = both;
        expected_records.push_back(r);
    endtask

    // expected records for one accepted byte pair
    task automatic predict_records(input t_item req);
        logic [31:0] nxt;
        logic [3:0]  blk_size;
        logic        ign_a, ign_b, tail;
        logic [7:0]  val_a, val_b;
        logic [32:0] used;
        t_record     sum;
        nxt = cmp_pos + 32'd1;
        blk_size = 4'd1 << cur_align;
        if (blk_fill == 4'd0) begin
            blk_start = cmp_pos;
            blk_first_both = req.has_a && req.has_b;
        end
        // absent bytes are ignored and read as zero
        ign_a = !req.has_a || in_ignore_set(req.byte_a);
        ign_b = !req.has_b || in_ignore_set(req.byte_b);
        val_a = req.has_a ? req.byte_a : 8'd0;
        val_b = req.has_b ? req.byte_b : 8'd0;
        if (!(ign_a && ign_b) && val_a != val_b) blk_diff = 1'b1;
        if (req.has_a) len_a = nxt;
        if (req.has_b) len_b = nxt;
        blk_fill = blk_fill + 4'd1;
        cmp_pos = nxt;

        // block closes when full or at the end of the comparison
        if (blk_fill >= blk_size || req.last_item) begin
            blk_total = blk_total + 32'd1;
            compared = compared + blk_fill;
            if (blk_diff) begin
                if (!in_run) begin
                    in_run = 1'b1;
                    run_start = blk_start;
                    run_both = blk_first_both;
                    if (run_both) changed = changed + 32'd1;
                end
            end else begin
                matched = matched + blk_fill;
                if (in_run) begin
                    expect_span(KIND_RUN, run_start, blk_start - run_start, run_both);
                    in_run = 1'b0;
                end
            end
            blk_fill = '0;
            blk_diff = 1'b0;
        end

        // open run, tail and summary
        if (req.last_item) begin
            tail = 1'b0;
            if (in_run) expect_span(KIND_RUN, run_start, cmp_pos - run_start, run_both);
            if (len_b > len_a) begin
                expect_span(KIND_ADDED, len_a, len_b - len_a, 1'b0);
                tail = 1'b1;
            end else if (len_a > len_b) begin
                expect_span(KIND_REMOVED, len_b, len_a - len_b, 1'b0);
                tail = 1'b1;
            end
            used = {1'b0, changed} + tail;
            sum = '0;
            sum.kind = KIND_SUMMARY;
            sum.matched = matched;
            sum.compared = compared;
            sum.total = blk_total;
            sum.changed = changed;
            sum.unchanged = ({1'b0, blk_total} > used) ? blk_total - used[31:0] : '0;
            sum.last = 1'b1;
            expected_records.push_back(sum);
            clear_compare_state();
        end
    endtask

    function automatic string describe(input t_record r);
        return $sformatf({"kind=%0d addr=%h len=%0d both=%0d match=%0d cmp=%0d ",
                          "tot=%0d chg=%0d unch=%0d last=%0d"},
                         r.kind, r.address, r.length, r.both, r.matched, r.compared,
                         r.total, r.changed, r.unchanged, r.last);
    endfunction

    task automatic flag_mismatch(input string why, input t_record want, input t_record got);
        fails++;
        if (fails <= REPORT_MAX) begin
            $display("[%0t] mismatch: %s", $realtime, why);
            $display("    expected %s", describe(want));
            $display("    actual   %s", describe(got));
        end
    endtask

    // length of an idle stretch: mostly none, mostly short when there is one
    function automatic int draw_gap(input int mode);
        int chance;
        chance = (mode == IDLE_NONE) ? 0 : (mode == IDLE_LIGHT) ? 15 : 45;
        if ($urandom_range(99) >= chance) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // request driver
    always @(negedge i_clk) begin : drive_pairs
        t_item nxt_item;
        int    gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap != 0) begin
                gap = gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                nxt_item = pending_items.pop_front();
                i_in_valid  <= 1'b1;
                i_byte_a    <= nxt_item.byte_a;
                i_byte_b    <= nxt_item.byte_b;
                i_has_a     <= nxt_item.has_a;
                i_has_b     <= nxt_item.has_b;
                i_last_item <= nxt_item.last_item;
                gap = draw_gap(in_idle_mode);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // record receiver, random stalls plus the long hold-off on request
    always @(negedge i_clk) begin : drive_stall
        int stall_left;
        int hold_left;
        int hold_served;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            stall_left = draw_gap(out_idle_mode);
            i_out_stall <= 1'b0;
        end
    end

    // monitor: register copies, prediction, record checks, watchdog
    always @(posedge i_clk) begin : monitor
        bit      cfg_acc, out_acc;
        int      quiet;
        t_item   req;
        t_record got;
        t_record want;
        if (i_rst_n) begin
            cfg_acc = i_cfg_valid && o_cfg_ready;
            in_taken = i_in_valid && !o_in_stall;
            out_acc = o_out_valid && !i_out_stall;

            if (cfg_acc) begin
                case (i_cfg_index)
                    CFG_ALIGN: cur_align = i_cfg_data[1:0];
                    CFG_BASE:  cur_base = i_cfg_data[31:0];
                    CFG_IGN0:  cur_ignore[0] = i_cfg_data;
                    CFG_IGN1:  cur_ignore[1] = i_cfg_data;
                    CFG_IGN2:  cur_ignore[2] = i_cfg_data;
                    CFG_IGN3:  cur_ignore[3] = i_cfg_data;
                    default: ;
                endcase
            end

            if (in_taken) begin
                req.byte_a = i_byte_a;
                req.byte_b = i_byte_b;
                req.has_a = i_has_a;
                req.has_b = i_has_b;
                req.last_item = i_last_item;
                pairs_taken++;
                if (i_last_item) compares_done++;
                predict_records(req);
            end

            if (out_acc) begin
                got.kind = t_kind'(o_record_kind);
                got.address = o_address;
                got.length = o_length;
                got.both = o_both_present;
                got.matched = o_matched_bytes;
                got.compared = o_compared_bytes;
                got.total = o_total_blocks;
                got.changed = o_changed_runs;
                got.unchanged = o_unchanged_blocks;
                got.last = o_last_result;
                case (got.kind)
                    KIND_RUN:     runs_seen++;
                    KIND_SUMMARY: summaries_seen++;
                    default:      tails_seen++;
                endcase
                if (expected_records.size() == 0) begin
                    flag_mismatch("record with nothing expected", '0, got);
                end else begin
                    want = expected_records.pop_front();
                    if (got !== want) flag_mismatch("record fields differ", want, got);
                end
            end

            // watchdog on cycles without any handshake
            if (cfg_acc || in_taken || out_acc) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d records outstanding",
                         quiet, expected_records.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // full register set, unused upper data bits filled with noise
    task automatic apply_settings(input logic [1:0] align, input logic [31:0] base,
                                  input logic [3:0][63:0] ign);
        write_reg(CFG_ALIGN, {$urandom, 30'($urandom_range(32'h3fff_ffff)), align});
        write_reg(CFG_BASE, {$urandom, base});
        write_reg(CFG_IGN0, ign[0]);
        write_reg(CFG_IGN1, ign[1]);
        write_reg(CFG_IGN2, ign[2]);
        write_reg(CFG_IGN3, ign[3]);
        if ($urandom_range(1)) write_reg(CFG_SPARE_LO, {$urandom, $urandom});
        else write_reg(CFG_SPARE_HI, {$urandom, $urandom});
        n_settings++;
    endtask

    task automatic push_item(input logic [7:0] a, input logic [7:0] b,
                             input logic ha, input logic hb, input logic last);
        t_item it;
        it.byte_a = a;
        it.byte_b = b;
        it.has_a = ha;
        it.has_b = hb;
        it.last_item = last;
        pending_items.push_back(it);
    endtask

    // bias towards the values most often put in the ignore set
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 12) return 8'h00;
        if (roll < 20) return 8'hff;
        return 8'($urandom);
    endfunction

    // one comparison: images of given lengths, differences in short bursts
    task automatic queue_compare(input int n_pos, input int a_len, input int b_len,
                                 input bit flag_noise);
        int         burst;
        logic       ha, hb;
        logic [7:0] va, vb;
        burst = 0;
        for (int p = 0; p < n_pos; p++) begin
            ha = p < a_len;
            hb = p < b_len;
            if (flag_noise) begin
                ha = $urandom_range(1);
                hb = $urandom_range(1);
            end
            va = pick_byte();
            vb = va;
            if (burst == 0 && $urandom_range(99) < 12) burst = $urandom_range(6, 1);
            if (burst != 0) begin
                vb = pick_byte();
                burst--;
            end
            push_item(va, vb, ha, hb, p == n_pos - 1);
        end
    endtask

    // idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_records.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int               phase, phase_items, random_items;
        int               n_pos, a_len, b_len, shape;
        logic [1:0]       align;
        logic [31:0]      base;
        logic [3:0][63:0] ign;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 4 byte blocks, base just below the wrap, 0x00 and 0xff ignored
        in_idle_mode = IDLE_LIGHT;
        out_idle_mode = IDLE_LIGHT;
        ign = '0;
        ign[0][0] = 1'b1;
        ign[3][63] = 1'b1;
        apply_settings(2'd2, 32'hffff_fff8, ign);
        @(posedge i_clk);
        // both bytes ignored, then a differing block, then a matching block
        push_item(8'h00, 8'hff, 1'b1, 1'b1, 1'b0);
        push_item(8'h12, 8'h12, 1'b1, 1'b1, 1'b0);
        push_item(8'h12, 8'h13, 1'b1, 1'b1, 1'b0);
        push_item(8'hff, 8'hff, 1'b1, 1'b1, 1'b0);
        push_item(8'h34, 8'h34, 1'b1, 1'b1, 1'b0);
        push_item(8'h56, 8'h56, 1'b1, 1'b1, 1'b0);
        push_item(8'h78, 8'h78, 1'b1, 1'b1, 1'b0);
        push_item(8'h9a, 8'h9a, 1'b1, 1'b1, 1'b0);
        // b ends: absent byte reads as zero, partial last block, removed tail
        push_item(8'h80, 8'h00, 1'b1, 1'b0, 1'b0);
        push_item(8'h7f, 8'haa, 1'b1, 1'b0, 1'b1);
        // single position only in b: added tail
        push_item(8'h00, 8'h55, 1'b0, 1'b1, 1'b1);
        // single position in neither image
        push_item(8'hff, 8'h00, 1'b0, 1'b0, 1'b1);
        // one side ignored but the other not: still a difference
        push_item(8'h00, 8'h05, 1'b1, 1'b1, 1'b0);
        push_item(8'h05, 8'h00, 1'b1, 1'b1, 1'b0);
        push_item(8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
        push_item(8'hff, 8'hff, 1'b1, 1'b1, 1'b1);
        wait_drained();

        // random phases, each under a fresh register setting
        phase = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            align = 2'($urandom_range(3));
            base = $urandom_range(3) == 0 ? 32'hffff_ffff - $urandom_range(64) : $urandom;
            for (int m = 0; m < 4; m++)
                ign[m] = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            case (phase)
                0: begin
                    align = 2'd0;
                    base = '0;
                    ign = '0;
                end
                1: begin
                    align = 2'd3;
                    base = 32'hffff_ffff;
                end
                3: ign = '1;
                default: ;
            endcase
            apply_settings(align, base, ign);

            // the pressure phases offer back to back, phase 2 into a long hold-off
            if (phase == 2 || phase == 5) begin
                in_idle_mode = IDLE_NONE;
                out_idle_mode = IDLE_NONE;
            end else begin
                in_idle_mode = $urandom_range(IDLE_HEAVY);
                out_idle_mode = $urandom_range(IDLE_HEAVY);
            end
            @(posedge i_clk);

            phase_items = 0;
            while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
                n_pos = ($urandom_range(9) < 8) ? $urandom_range(16, 1) : $urandom_range(48, 17);
                a_len = n_pos;
                b_len = n_pos;
                shape = $urandom_range(9);
                if (shape == 6 || shape == 7) a_len = $urandom_range(n_pos);
                else if (shape == 8) b_len = $urandom_range(n_pos);
                else if (shape == 9) begin
                    a_len = $urandom_range(n_pos);
                    b_len = $urandom_range(n_pos);
                end
                queue_compare(n_pos, a_len, b_len, $urandom_range(4) == 0);
                phase_items += n_pos;
                random_items += n_pos;
            end
            if (phase == 2) hold_asked++;
            wait_drained();
            phase++;
        end

        if (expected_records.size() != 0) begin
            fails += expected_records.size();
            $display("%0d expected records never arrived", expected_records.size());
        end
        $display("%0d byte pairs in %0d comparisons over %0d register settings",
                 pairs_taken, compares_done, n_settings);
        $display("records checked: %0d runs, %0d tails, %0d summaries, %0d mismatches",
                 runs_seen, tails_seen, summaries_seen, fails);
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ aligned_block_binary_differ.f @@
design/abd_pkg.sv
design/abd_cfg.sv
design/abd_core.sv
design/abd_out.sv
design/aligned_block_binary_differ.sv
design/abd_checker.sv
verif/tb.sv
